// ===== src/far_pkg.sv =====
// ----------------------------------------------------------------------------
// Fraction add-reduce package
// Widths, controller state encoding and the command/status structs shared
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package far_pkg;

  localparam int unsigned OperandWidth = 16;
  localparam int unsigned DenWidth     = 2 * OperandWidth;
  localparam int unsigned NumWidth     = 2 * OperandWidth + 1;
  localparam int unsigned CountWidth   = $clog2(NumWidth + 1);

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_MUL   = 7'b0000010,
    ST_SUM   = 7'b0000100,
    ST_GCD   = 7'b0001000,
    ST_DIVN  = 7'b0010000,
    ST_DIVD  = 7'b0100000,
    ST_OUT   = 7'b1000000
  } state_t;

  typedef struct packed {
    logic load;
    logic mul;
    logic sum;
    logic gcd_step;
    logic div_start_num;
    logic div_start_den;
    logic div_step;
  } cmd_t;

  typedef struct packed {
    logic gcd_done;
    logic div_done;
  } status_t;

endpackage

// ===== src/far_datapath.sv =====
// ----------------------------------------------------------------------------
// Fraction add-reduce datapath
// Products, cross sum, subtractive binary GCD and a restoring bit-serial
// divider shared by the numerator and denominator divisions.
// ----------------------------------------------------------------------------
module far_datapath (
  input  logic                                 clk,
  input  far_pkg::cmd_t                        cmd,
  output far_pkg::status_t                     status,
  input  logic [far_pkg::OperandWidth-1:0]     a_num,
  input  logic [far_pkg::OperandWidth-1:0]     a_den,
  input  logic [far_pkg::OperandWidth-1:0]     b_num,
  input  logic [far_pkg::OperandWidth-1:0]     b_den,
  output logic [far_pkg::NumWidth-1:0]         sum_num,
  output logic [far_pkg::DenWidth-1:0]         sum_den
);

  localparam int unsigned W  = far_pkg::OperandWidth;
  localparam int unsigned NW = far_pkg::NumWidth;
  localparam int unsigned DW = far_pkg::DenWidth;
  localparam int unsigned CW = far_pkg::CountWidth;

  logic [W-1:0]    an_r, ad_r, bn_r, bd_r;
  logic [DW-1:0]   p1_r, p2_r, den_r;
  logic [NW-1:0]   num_r;
  logic [NW-1:0]   gu_r, gv_r;
  logic [CW-1:0]   gk_r;
  logic [NW-1:0]   gdiv_r;
  logic [NW-1:0]   dq_r, drem_r, sum_num_r;
  logic [CW-1:0]   dcnt_r;
  logic [NW:0]     dtrial;
  logic [NW-1:0]   drem_sh;
  logic            gcd_done, div_done;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      an_r <= a_num;
      ad_r <= a_den;
      bn_r <= b_num;
      bd_r <= b_den;
    end
    if (cmd.mul) begin
      p1_r  <= DW'(an_r) * DW'(bd_r);
      p2_r  <= DW'(bn_r) * DW'(ad_r);
      den_r <= DW'(ad_r) * DW'(bd_r);
    end
    if (cmd.sum) begin
      num_r <= {1'b0, p1_r} + {1'b0, p2_r};
      gu_r  <= {1'b0, p1_r} + {1'b0, p2_r};
      gv_r  <= {1'b0, den_r};
      gk_r  <= '0;
    end
    // Binary GCD over u, v with the shared factor of two counted in gk_r.
    if (cmd.gcd_step) begin
      if (!gu_r[0] && !gv_r[0]) begin
        gu_r <= gu_r >> 1;
        gv_r <= gv_r >> 1;
        gk_r <= gk_r + CW'(1);
      end else if (!gu_r[0]) begin
        gu_r <= gu_r >> 1;
      end else if (!gv_r[0]) begin
        gv_r <= gv_r >> 1;
      end else if (gu_r >= gv_r) begin
        gu_r <= (gu_r - gv_r) >> 1;
      end else begin
        gv_r <= (gv_r - gu_r) >> 1;
      end
    end
    if (cmd.div_start_num) begin
      if (num_r == '0 || den_r == '0) begin
        gdiv_r <= NW'(1);
      end else begin
        gdiv_r <= (gu_r == '0) ? (gv_r << gk_r) : (gu_r << gk_r);
      end
      dq_r   <= num_r;
      drem_r <= '0;
      dcnt_r <= '0;
    end else if (cmd.div_start_den) begin
      sum_num_r <= dq_r;
      dq_r      <= {1'b0, den_r};
      drem_r    <= '0;
      dcnt_r    <= '0;
    end else if (cmd.div_step) begin
      if (!dtrial[NW]) begin
        drem_r <= dtrial[NW-1:0];
        dq_r   <= {dq_r[NW-2:0], 1'b1};
      end else begin
        drem_r <= drem_sh;
        dq_r   <= {dq_r[NW-2:0], 1'b0};
      end
      dcnt_r <= dcnt_r + CW'(1);
    end
  end

  assign drem_sh = {drem_r[NW-2:0], dq_r[NW-1]};
  assign dtrial  = {1'b0, drem_sh} - {1'b0, gdiv_r};

  assign gcd_done = (gu_r == '0) || (gv_r == '0);
  assign div_done = (dcnt_r == CW'(NW));
  assign status   = '{gcd_done: gcd_done, div_done: div_done};

  assign sum_num = sum_num_r;
  assign sum_den = dq_r[DW-1:0];

endmodule

// ===== src/far_ctrl.sv =====
// ----------------------------------------------------------------------------
// Fraction add-reduce controller
// Sequences load, multiply, sum, GCD and the two divisions, then holds the
// result for one transfer.
// ----------------------------------------------------------------------------
module far_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_fire,
  input  logic             out_fire,
  input  far_pkg::status_t status,
  output far_pkg::cmd_t    cmd,
  output logic             busy,
  output logic             out_valid
);

  far_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= far_pkg::ST_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      far_pkg::ST_IDLE: begin
        if (in_fire) begin
          cmd.load  = 1'b1;
          state_nxt = far_pkg::ST_MUL;
        end
      end
      far_pkg::ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = far_pkg::ST_SUM;
      end
      far_pkg::ST_SUM: begin
        cmd.sum   = 1'b1;
        state_nxt = far_pkg::ST_GCD;
      end
      far_pkg::ST_GCD: begin
        if (status.gcd_done) begin
          cmd.div_start_num = 1'b1;
          state_nxt         = far_pkg::ST_DIVN;
        end else begin
          cmd.gcd_step = 1'b1;
        end
      end
      far_pkg::ST_DIVN: begin
        if (status.div_done) begin
          cmd.div_start_den = 1'b1;
          state_nxt         = far_pkg::ST_DIVD;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      far_pkg::ST_DIVD: begin
        if (status.div_done) begin
          state_nxt = far_pkg::ST_OUT;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      far_pkg::ST_OUT: if (out_fire) state_nxt = far_pkg::ST_IDLE;
      default: state_nxt = far_pkg::ST_IDLE;
    endcase
  end

  assign busy      = (state_r != far_pkg::ST_IDLE);
  assign out_valid = (state_r == far_pkg::ST_OUT);

endmodule

// ===== src/fraction_add_reduce_unit.sv =====
// ----------------------------------------------------------------------------
// Fraction add-reduce unit
// Adds two unsigned fractions and reduces the sum to lowest terms.
// ----------------------------------------------------------------------------
//  Channel | Role   | tdata fields (low bit up)
//  in_     | slave  | a_num[15:0], a_den[31:16], b_num[47:32], b_den[63:48]
//  out_    | master | sum_num[32:0], sum_den[64:33], zero pad[71:65]
//
//  One item at a time: out_tvalid rises after the input transfer once the
//  multiply, sum, GCD steps (none for a zero sum or denominator) and both
//  33-step bit-serial divisions are done, the divisions taking most of the time.
//  in_tready returns the cycle after the result transfer; a stalled result holds.
//  Reset returns the controller to idle; datapath registers are not reset.
// ----------------------------------------------------------------------------
module fraction_add_reduce_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // a_num, a_den, b_num, b_den
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata   // sum_num, sum_den, zero pad
);

  localparam int unsigned W  = far_pkg::OperandWidth;
  localparam int unsigned NW = far_pkg::NumWidth;
  localparam int unsigned DW = far_pkg::DenWidth;

  far_pkg::cmd_t    cmd;
  far_pkg::status_t status;
  logic             busy, out_valid;
  logic             in_fire, out_fire;
  logic [NW-1:0]    sum_num;
  logic [DW-1:0]    sum_den;

  assign in_fire    = in_tvalid && in_tready;
  assign out_fire   = out_tvalid && out_tready;
  assign in_tready  = !busy;
  assign out_tvalid = out_valid;

  far_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_fire),
    .out_fire  (out_fire),
    .status    (status),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  far_datapath u_datapath (
    .clk     (clk),
    .cmd     (cmd),
    .status  (status),
    .a_num   (in_tdata[W-1:0]),
    .a_den   (in_tdata[2*W-1:W]),
    .b_num   (in_tdata[3*W-1:2*W]),
    .b_den   (in_tdata[4*W-1:3*W]),
    .sum_num (sum_num),
    .sum_den (sum_den)
  );

  assign out_tdata = {7'd0, sum_den, sum_num};

  a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid)) else $error("accept while result pending");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");
  a_in_drop: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("ready held after input transfer");

endmodule
